[rtl/pwsc_pkg.sv]
// Shared types and constants for the PCM wavetable sound generator.
package pwsc_pkg;

  typedef enum logic [1:0] {
    OP_REG_WR = 2'd0,
    OP_RAM_WR = 2'd1,
    OP_RAM_RD = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] offset;
    logic [7:0]  wdata;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CH,
    ST_ADDR,
    ST_DATA,
    ST_VL,
    ST_VR,
    ST_ML,
    ST_ACC,
    ST_EMIT
  } state_t;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [11:0] REG_ENV     = 12'd0;
  localparam logic [11:0] REG_PAN     = 12'd1;
  localparam logic [11:0] REG_FREQ_LO = 12'd2;
  localparam logic [11:0] REG_FREQ_HI = 12'd3;
  localparam logic [11:0] REG_LOOP_LO = 12'd4;
  localparam logic [11:0] REG_LOOP_HI = 12'd5;
  localparam logic [11:0] REG_START   = 12'd6;
  localparam logic [11:0] REG_SELECT  = 12'd7;
  localparam logic [11:0] REG_KEYON   = 12'd8;

  localparam logic [15:0] STEP_RATIO_RESET = 16'd256;
  localparam logic [7:0]  KEYON_RESET      = 8'hFF;
  localparam logic [7:0]  LOOP_MARKER      = 8'hFF;
  localparam logic [7:0]  NEG_BASE         = 8'd127;
  localparam int          SEL_BANK_MODE    = 6;

endpackage

[rtl/pcm_wavetable_sound_chip_top.sv]
// A sample tick steps through the channels in turn; a keyed-on channel runs the ADDR, DATA,
// VL, VR, ML and ACC states (ADDR and DATA again when a loop marker is hit), a keyed-off
// channel is skipped in ST_CH; one transaction is in flight at a time.
// The single shared 17x17 multiplier and the one wave RAM port set this sequence.
// Reset (rst_n, synchronous): channel registers, select and phases clear, all
// channels keyed off, step ratio 256; wave RAM contents are not cleared.
module pcm_wavetable_sound_chip_top #(
  parameter int NUM_CHANNELS  = 8,
  parameter int RAM_ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pwsc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import pwsc_pkg::*;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  state_t state_r, state_nxt;

  op_t         op_r;
  logic [11:0] offset_r;
  logic [7:0]  wdata_r;

  logic [15:0] step_ratio_r;
  logic [7:0]  select_r;
  logic [7:0]  keyon_r;
  logic [7:0]  env_r     [NUM_CHANNELS];
  logic [7:0]  pan_r     [NUM_CHANNELS];
  logic [7:0]  freq_lo_r [NUM_CHANNELS];
  logic [7:0]  freq_hi_r [NUM_CHANNELS];
  logic [7:0]  loop_lo_r [NUM_CHANNELS];
  logic [7:0]  loop_hi_r [NUM_CHANNELS];
  logic [7:0]  start_r   [NUM_CHANNELS];
  logic [31:0] phase_r   [NUM_CHANNELS];

  logic [CH_W-1:0]    ch_r;
  logic               looped_r;
  logic [31:0]        phase_work_r;
  logic [23:0]        step_r;
  logic signed [7:0]  sample_r;
  logic signed [33:0] prod_r;
  logic [15:0]        left_sum_r;
  logic [15:0]        right_sum_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic                     ram_en;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]               ram_rdata;

  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod_shift;

  logic            sel_valid;
  logic [CH_W-1:0] sel_idx;
  logic [15:0]     win_base;
  logic [15:0]     win_addr;
  logic [7:0]      keyon_start;
  logic            out_free;
  logic            marker_hit;
  logic [7:0]      sample_nxt;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || out_ready;

  assign sel_valid   = (32'(select_r[2:0]) < NUM_CHANNELS);
  assign sel_idx     = select_r[CH_W-1:0];
  assign keyon_start = keyon_r & ~wdata_r;
  assign prod_shift  = prod_r >>> 5;
  assign marker_hit  = (ram_rdata == LOOP_MARKER) && !looped_r;
  assign sample_nxt  = ram_rdata[7] ? 8'(NEG_BASE - ram_rdata) : ram_rdata;

  always_comb begin
    if (select_r[SEL_BANK_MODE]) begin
      win_base = sel_valid ? {start_r[sel_idx], 8'd0} : 16'd0;
    end else begin
      win_base = {select_r[3:0], 12'd0};
    end
    win_addr = win_base + {4'd0, offset_r};
  end

  pwsc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_wave_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_r) inside
          OP_REG_WR, OP_RAM_WR: state_nxt = ST_IDLE;
          OP_RAM_RD:            state_nxt = ST_EMIT;
          OP_TICK:              state_nxt = ST_CH;
          default:              state_nxt = ST_IDLE;
        endcase
      end
      ST_CH: begin
        if (!keyon_r[ch_r]) begin
          state_nxt = ST_ADDR;
        end else if (ch_r == LAST_CH) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ADDR: state_nxt = ST_DATA;
      ST_DATA: state_nxt = marker_hit ? ST_ADDR : ST_VL;
      ST_VL:   state_nxt = ST_VR;
      ST_VR:   state_nxt = ST_ML;
      ST_ML:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (ch_r == LAST_CH) ? ST_EMIT : ST_CH;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = win_addr[RAM_ADDR_BITS-1:0];
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r) inside
      ST_DECODE: begin
        ram_en = (op_r == OP_RAM_WR) || (op_r == OP_RAM_RD);
        ram_we = (op_r == OP_RAM_WR);
      end
      ST_ADDR: begin
        ram_en   = 1'b1;
        ram_addr = phase_work_r[16 +: RAM_ADDR_BITS];
        mul_a    = {1'b0, freq_hi_r[ch_r], freq_lo_r[ch_r]};
        mul_b    = {1'b0, step_ratio_r};
      end
      ST_DATA: begin
        mul_a = {9'd0, env_r[ch_r]};
        mul_b = {13'd0, pan_r[ch_r][3:0]};
      end
      ST_VL, ST_ML: begin
        mul_a = {{9{sample_r[7]}}, sample_r};
        mul_b = prod_r[16:0];
      end
      ST_VR: begin
        mul_a = {9'd0, env_r[ch_r]};
        mul_b = {13'd0, pan_r[ch_r][7:4]};
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_ratio_r <= STEP_RATIO_RESET;
      select_r    <= '0;
      keyon_r     <= KEYON_RESET;
      ch_r        <= '0;
      looped_r    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        env_r[i]     <= '0;
        pan_r[i]     <= '0;
        freq_lo_r[i] <= '0;
        freq_hi_r[i] <= '0;
        loop_lo_r[i] <= '0;
        loop_hi_r[i] <= '0;
        start_r[i]   <= '0;
        phase_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) step_ratio_r <= cfg_data;
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_DECODE: begin
          if (op_r == OP_REG_WR) begin
            unique case (offset_r)
              REG_ENV:     if (sel_valid) env_r[sel_idx]     <= wdata_r;
              REG_PAN:     if (sel_valid) pan_r[sel_idx]     <= wdata_r;
              REG_FREQ_LO: if (sel_valid) freq_lo_r[sel_idx] <= wdata_r;
              REG_FREQ_HI: if (sel_valid) freq_hi_r[sel_idx] <= wdata_r;
              REG_LOOP_LO: if (sel_valid) loop_lo_r[sel_idx] <= wdata_r;
              REG_LOOP_HI: if (sel_valid) loop_hi_r[sel_idx] <= wdata_r;
              REG_START:   if (sel_valid) start_r[sel_idx]   <= wdata_r;
              REG_SELECT:  select_r <= wdata_r;
              REG_KEYON: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (keyon_start[i]) phase_r[i] <= {start_r[i], 24'd0};
                end
                keyon_r <= wdata_r;
              end
              default: ;
            endcase
          end
          ch_r <= '0;
        end
        ST_CH: begin
          looped_r <= 1'b0;
          if (keyon_r[ch_r] && (ch_r != LAST_CH)) ch_r <= ch_r + 1'b1;
        end
        ST_DATA: begin
          if (marker_hit) looped_r <= 1'b1;
        end
        ST_ACC: begin
          phase_r[ch_r] <= phase_work_r + {8'd0, step_r};
          if (ch_r != LAST_CH) ch_r <= ch_r + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_valid && in_ready) begin
      op_r     <= in_data.op;
      offset_r <= in_data.offset;
      wdata_r  <= in_data.wdata;
    end
    unique case (state_r)
      ST_DECODE: begin
        left_sum_r  <= '0;
        right_sum_r <= '0;
      end
      ST_CH: begin
        phase_work_r <= phase_r[ch_r];
      end
      ST_DATA: begin
        step_r <= prod_r[31:8];
        if (marker_hit) begin
          phase_work_r <= {loop_hi_r[ch_r], loop_lo_r[ch_r], 16'd0};
        end else begin
          sample_r <= sample_nxt;
        end
      end
      ST_VR: begin
        left_sum_r <= left_sum_r + prod_shift[15:0];
      end
      ST_ACC: begin
        right_sum_r <= right_sum_r + prod_shift[15:0];
      end
      ST_EMIT: begin
        if (out_free) begin
          if (op_r == OP_TICK) begin
            out_data_r.kind         <= KIND_SAMPLE;
            out_data_r.read_data    <= '0;
            out_data_r.left_sample  <= $signed(left_sum_r);
            out_data_r.right_sample <= $signed(right_sum_r);
          end else begin
            out_data_r.kind         <= KIND_READ;
            out_data_r.read_data    <= ram_rdata;
            out_data_r.left_sample  <= '0;
            out_data_r.right_sample <= '0;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result raised outside the emit state");

  a_ram_write_decode: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_DECODE) && (op_r == OP_RAM_WR))
    else $error("wave RAM written outside a RAM write transaction");

  a_sums_clear_at_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CH) && (ch_r == '0) |-> (left_sum_r == '0) && (right_sum_r == '0))
    else $error("mix sums not cleared at the first channel");

  a_loop_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) && looped_r |=> state_r == ST_VL)
    else $error("loop marker followed more than once");
`endif

endmodule

[rtl/pwsc_ram.sv]
// Single-port RAM with registered read data.
module pwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for pcm_wavetable_sound_chip_top: directed table, then checked random traffic.
module testbench;
  import pwsc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    op_t                op;
    logic [11:0]        offset;
    logic [7:0]         wdata;
    logic               pinned;
    logic [7:0]         rd;
    logic signed [15:0] l;
    logic signed [15:0] r;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [7:0]  voice_reg [8][7];
  logic [31:0] voice_phase [8];
  logic [7:0]  sel_q;
  logic [7:0]  key_mask;
  logic [15:0] ratio_q;
  logic [7:0]  wave_mem [65536];
  bit          wave_set [65536];

  out_item_t awaited_outputs [$];
  out_item_t head;
  int        mism = 0;
  int        sent = 0;
  int        snd_idle = 6;
  int        rcv_idle = 62;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        stall_cycles = 0;

  dir_row_t dir_rows [26] = '{
    '{OP_TICK,   12'h000,     8'h00, 1'b1, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_WR, 12'hFFF,     8'hA5, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_RD, 12'hFFF,     8'h00, 1'b1, 8'hA5, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_SELECT,  8'h0F, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_WR, 12'h000,     8'h7F, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_RD, 12'h000,     8'h00, 1'b1, 8'h7F, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_ENV,     8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_PAN,     8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_FREQ_LO, 8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_FREQ_HI, 8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_LOOP_LO, 8'h00, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_LOOP_HI, 8'h00, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_START,   8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, 12'hFFF,     8'h5A, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_SELECT,  8'h47, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_WR, 12'h000,     8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_WR, 12'h100,     8'h80, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_RAM_RD, 12'h100,     8'h00, 1'b1, 8'h80, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_KEYON,   8'h7F, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_TICK,   12'h000,     8'h00, 1'b1, 8'h00, -16'sd120,   -16'sd120},
    '{OP_TICK,   12'h000,     8'h00, 1'b1, 8'h00, -16'sd120,   -16'sd120},
    '{OP_REG_WR, REG_LOOP_HI, 8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_KEYON,   8'hFF, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_REG_WR, REG_KEYON,   8'h7F, 1'b0, 8'h00, 16'sd0,      16'sd0},
    '{OP_TICK,   12'h000,     8'h00, 1'b1, 8'h00, -16'sd15300, -16'sd15300},
    '{OP_TICK,   12'h000,     8'h00, 1'b1, 8'h00, -16'sd15300, -16'sd15300}
  };

  pcm_wavetable_sound_chip_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t item_of(input op_t op, input logic [11:0] off,
                                       input logic [7:0] d);
    in_item_t it;
    it.op = op;
    it.offset = off;
    it.wdata = d;
    return it;
  endfunction

  function automatic logic [15:0] window_of(input logic [11:0] off);
    logic [15:0] base;
    if (sel_q[SEL_BANK_MODE]) begin
      base = {voice_reg[sel_q[2:0]][REG_START], 8'h00};
    end else begin
      base = {sel_q[3:0], 12'h000};
    end
    return base + {4'h0, off};
  endfunction

  function automatic bit emulate_chip(input in_item_t it, output out_item_t res);
    logic [7:0]  starting;
    logic [7:0]  b;
    logic [7:0]  env;
    logic [7:0]  pan;
    logic [15:0] a;
    logic [15:0] freq;
    logic [15:0] lsum;
    logic [15:0] rsum;
    logic [31:0] ph;
    logic [31:0] step;
    int          voll;
    int          volr;
    int          v;
    int          i;
    bit          has;
    res = '0;
    has = 1'b0;
    case (it.op)
      OP_REG_WR: begin
        if (it.offset == REG_SELECT) begin
          sel_q = it.wdata;
        end else if (it.offset == REG_KEYON) begin
          starting = key_mask & ~it.wdata;
          for (i = 0; i < 8; i++) begin
            if (starting[i]) voice_phase[i] = {voice_reg[i][REG_START], 24'h0};
          end
          key_mask = it.wdata;
        end else if (it.offset < REG_SELECT) begin
          voice_reg[sel_q[2:0]][it.offset[2:0]] = it.wdata;
        end
      end
      OP_RAM_WR: begin
        a = window_of(it.offset);
        wave_mem[a] = it.wdata;
        wave_set[a] = 1'b1;
      end
      OP_RAM_RD: begin
        res.kind = KIND_READ;
        res.read_data = wave_mem[window_of(it.offset)];
        has = 1'b1;
      end
      default: begin
        lsum = '0;
        rsum = '0;
        for (i = 0; i < 8; i++) begin
          if (!key_mask[i]) begin
            env = voice_reg[i][REG_ENV];
            pan = voice_reg[i][REG_PAN];
            voll = int'(pan[3:0]) * int'(env);
            volr = int'(pan[7:4]) * int'(env);
            freq = {voice_reg[i][REG_FREQ_HI], voice_reg[i][REG_FREQ_LO]};
            step = ({16'h0, freq} * {16'h0, ratio_q}) >> 8;
            ph = voice_phase[i];
            b = wave_mem[ph[31:16]];
            if (b == LOOP_MARKER) begin
              ph = {voice_reg[i][REG_LOOP_HI], voice_reg[i][REG_LOOP_LO], 16'h0};
              b = wave_mem[ph[31:16]];
            end
            v = b[7] ? int'(NEG_BASE) - int'(b) : int'(b);
            lsum += 16'((v * voll) >>> 5);
            rsum += 16'((v * volr) >>> 5);
            voice_phase[i] = ph + step;
          end
        end
        res.kind = KIND_SAMPLE;
        res.left_sample = lsum;
        res.right_sample = rsum;
        has = 1'b1;
      end
    endcase
    return has;
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(9))
      0: return LOOP_MARKER;
      1: return 8'h80;
      2: return 8'h7F;
      3: return 8'h00;
      4: return 8'hFE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input in_item_t it, input bit pinned = 1'b0,
                           input out_item_t pin_res = '0);
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (emulate_chip(it, res)) awaited_outputs.push_back(pinned ? pin_res : res);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    quiet_input();
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ratio(input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ratio_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_byte(input logic [15:0] a);
    logic [7:0] keep;
    keep = sel_q;
    send_item(item_of(OP_REG_WR, REG_SELECT, {4'h0, a[15:12]}));
    send_item(item_of(OP_RAM_WR, a[11:0], pick_sample()));
    send_item(item_of(OP_REG_WR, REG_SELECT, keep));
  endtask

  // Make sure every fetch of the coming tick lands on written wave RAM.
  task automatic feed_voices();
    logic [15:0] a;
    int          i;
    for (i = 0; i < 8; i++) begin
      if (!key_mask[i]) begin
        a = voice_phase[i][31:16];
        if (!wave_set[a]) fill_byte(a);
        if (wave_mem[a] == LOOP_MARKER) begin
          a = {voice_reg[i][REG_LOOP_HI], voice_reg[i][REG_LOOP_LO]};
          if (!wave_set[a]) fill_byte(a);
        end
      end
    end
  endtask

  task automatic setup_voice();
    logic [7:0] s;
    logic [7:0] fh;
    logic [7:0] bit_c;
    int         c;
    int         k;
    int         n_bytes;
    c = $urandom_range(7);
    bit_c = 8'h1 << c;
    s = 8'($urandom_range(255));
    s[2:0] = c[2:0];
    fh = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(2));
    send_item(item_of(OP_REG_WR, REG_SELECT, s));
    send_item(item_of(OP_REG_WR, REG_ENV, 8'($urandom_range(255))));
    send_item(item_of(OP_REG_WR, REG_PAN, 8'($urandom_range(255))));
    send_item(item_of(OP_REG_WR, REG_FREQ_LO, 8'($urandom_range(255))));
    send_item(item_of(OP_REG_WR, REG_FREQ_HI, fh));
    send_item(item_of(OP_REG_WR, REG_LOOP_LO, 8'($urandom_range(255))));
    send_item(item_of(OP_REG_WR, REG_LOOP_HI, 8'($urandom_range(255))));
    send_item(item_of(OP_REG_WR, REG_START, 8'($urandom_range(255))));
    s[SEL_BANK_MODE] = 1'b1;
    send_item(item_of(OP_REG_WR, REG_SELECT, s));
    n_bytes = $urandom_range(1, 4);
    for (k = 0; k < n_bytes; k++) begin
      send_item(item_of(OP_RAM_WR, 12'(k), pick_sample()));
    end
    send_item(item_of(OP_REG_WR, REG_KEYON, key_mask | bit_c));
    send_item(item_of(OP_REG_WR, REG_KEYON, key_mask & ~bit_c));
  endtask

  task automatic random_action();
    logic [11:0] off;
    logic [7:0]  d;
    int          r;
    r = $urandom_range(99);
    if (r < 12) begin
      setup_voice();
    end else if (r < 32) begin
      off = 12'($urandom_range(6));
      d = 8'($urandom_range(255));
      if (off == REG_FREQ_HI && $urandom_range(3) != 0) d = 8'($urandom_range(2));
      send_item(item_of(OP_REG_WR, off, d));
    end else if (r < 38) begin
      send_item(item_of(OP_REG_WR, REG_SELECT, 8'($urandom_range(255))));
    end else if (r < 44) begin
      case ($urandom_range(3))
        0: d = KEYON_RESET;
        1: d = 8'h00;
        default: d = 8'($urandom_range(255));
      endcase
      send_item(item_of(OP_REG_WR, REG_KEYON, d));
    end else if (r < 47) begin
      send_item(item_of(OP_REG_WR, 12'($urandom_range(9, 4095)), 8'($urandom_range(255))));
    end else if (r < 58) begin
      send_item(item_of(OP_RAM_WR, 12'($urandom_range(4095)), pick_sample()));
    end else if (r < 70) begin
      off = 12'($urandom_range(4095));
      if (!wave_set[window_of(off)]) send_item(item_of(OP_RAM_WR, off, pick_sample()));
      send_item(item_of(OP_RAM_RD, off, 8'($urandom_range(255))));
    end else begin
      feed_voices();
      send_item(item_of(OP_TICK, 12'($urandom_range(4095)), 8'($urandom_range(255))));
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        $error("unexpected output transaction %h", out_data);
        mism++;
      end else begin
        head = awaited_outputs.pop_front();
        if (out_data.kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, out_data.kind);
          mism++;
        end
        if (out_data.read_data !== head.read_data) begin
          $error("read_data: expected %0h, got %0h", head.read_data, out_data.read_data);
          mism++;
        end
        if (out_data.left_sample !== head.left_sample) begin
          $error("left_sample: expected %0d, got %0d", head.left_sample,
                 out_data.left_sample);
          mism++;
        end
        if (out_data.right_sample !== head.right_sample) begin
          $error("right_sample: expected %0d, got %0d", head.right_sample,
                 out_data.right_sample);
          mism++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("pcm_wavetable_sound_chip_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int        n;
    int        i;
    int        j;
    out_item_t pin;
    for (i = 0; i < 8; i++) begin
      voice_phase[i] = '0;
      for (j = 0; j < 7; j++) voice_reg[i][j] = '0;
    end
    sel_q = '0;
    key_mask = KEYON_RESET;
    ratio_q = STEP_RATIO_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < 26; n++) begin
      pin = '0;
      pin.kind = (dir_rows[n].op == OP_RAM_RD) ? KIND_READ : KIND_SAMPLE;
      pin.read_data = dir_rows[n].rd;
      pin.left_sample = dir_rows[n].l;
      pin.right_sample = dir_rows[n].r;
      send_item(item_of(dir_rows[n].op, dir_rows[n].offset, dir_rows[n].wdata),
                dir_rows[n].pinned, pin);
    end

    settle();
    set_ratio(16'hFFFF);
    while (sent < 190) random_action();

    settle();
    snd_idle = 62;
    rcv_idle = 6;
    set_ratio(16'h0000);
    while (sent < 340) random_action();

    settle();
    snd_idle = 0;
    rcv_idle = 0;
    set_ratio(16'($urandom_range(65535)));
    n = 0;
    while (sent < 500 || n < 30) begin
      if (n == 5) hold_req = 1'b1;
      if (n == 20) begin
        quiet_input();
        while (awaited_outputs.size() != 0) @(posedge clk);
      end
      random_action();
      n++;
    end

    settle();
    if (mism == 0) begin
      $display("pcm_wavetable_sound_chip_top: match");
    end else begin
      $display("pcm_wavetable_sound_chip_top: mismatch");
    end
    $finish;
  end

endmodule
